### hdl/ssq_pkg.sv
// Shared types and constants for the sorted stack priority queue.
package ssq_pkg;

  localparam int DEFAULT_DEPTH = 64;
  localparam int VALUE_W       = 32;
  localparam int FILL_W        = 7;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic                      push;
    logic                      pop;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

### hdl/ssq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module ssq_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic                              clk,
  input  ssq_pkg::cell_cmd_t                cmd,
  input  logic [CNT_W-1:0]                  count,
  input  logic signed [ssq_pkg::VALUE_W-1:0] prev_entry,
  input  logic                              prev_gt,
  input  logic signed [ssq_pkg::VALUE_W-1:0] next_entry,
  output logic signed [ssq_pkg::VALUE_W-1:0] entry_q,
  output logic                              gt
);
  import ssq_pkg::*;

  logic signed [VALUE_W-1:0] entry_r, entry_nxt;
  logic                      occupied;
  logic                      in_reach;

  // The chain is kept in descending order from cell 0, so cell 0 is the top.
  assign occupied = CNT_W'(INDEX) < count;
  assign in_reach = CNT_W'(INDEX) <= count;
  assign gt       = occupied && (entry_r > cmd.value);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.pop) begin
      entry_nxt = next_entry;
    end else if (cmd.push && !gt && in_reach) begin
      // The first cell not above the value takes it; cells past it shift down.
      entry_nxt = prev_gt ? cmd.value : prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

### hdl/sorted_stack_priority_queue.sv
// Sorted stack priority queue: a chain of cells ordered by value, largest on top.
//
// Usage: each transfer on the input channel carries one operation, in_func
// (push of in_value at its sorted place, or pop of the largest entry), and
// produces exactly one transfer on the result channel with the popped value
// (zero unless a pop succeeded), a status code and the fill count after the
// operation. A push finding the store full is dropped with the full status;
// a pop on an empty store reports the empty status and changes nothing.
// out_valid rises in the cycle after the input transfer. Throughput is
// one operation per cycle: every cell compares against the broadcast value
// and loads from a neighbor in the same cycle, and the result register parts
// the two channels. When the receiver stalls a waiting result, in_stall is
// raised and input is held off until that result is taken. Synchronous reset
// empties the store and clears out_valid; entry contents are
// not cleared, since only slots below the fill count are ever read.
module sorted_stack_priority_queue #(
  parameter int DEPTH = ssq_pkg::DEFAULT_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic signed [ssq_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ssq_pkg::VALUE_W-1:0] out_popped_value,
  output logic [1:0]                         out_status,
  output logic [ssq_pkg::FILL_W-1:0]         out_fill_count
);
  import ssq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic signed [VALUE_W-1:0] cell_q [DEPTH];
  logic                      cell_gt [DEPTH];
  cell_cmd_t                 cmd;
  logic                      accept;
  logic                      is_full;
  logic                      is_empty;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] popped_r;
  status_t                   status_r, status_nxt;
  logic [FILL_W-1:0]         fill_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_full  = count_r == CNT_W'(DEPTH);
  assign is_empty = count_r == '0;

  assign cmd.push  = accept && (in_func == FUNC_PUSH) && !is_full;
  assign cmd.pop   = accept && (in_func == FUNC_POP) && !is_empty;
  assign cmd.value = in_value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] prev_entry;
    logic                      prev_gt;
    logic signed [VALUE_W-1:0] next_entry;

    if (i == 0) begin : g_first
      assign prev_entry = '0;
      assign prev_gt    = 1'b1;
    end else begin : g_mid
      assign prev_entry = cell_q[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_body
      assign next_entry = cell_q[i+1];
    end

    ssq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .prev_entry (prev_entry),
      .prev_gt    (prev_gt),
      .next_entry (next_entry),
      .entry_q    (cell_q[i]),
      .gt         (cell_gt[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (accept && (in_func == FUNC_PUSH) && is_full) begin
      status_nxt = ST_FULL;
    end else if (accept && (in_func == FUNC_POP) && is_empty) begin
      status_nxt = ST_EMPTY;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= cmd.pop ? cell_q[0] : '0;
      status_r <= status_nxt;
      fill_r   <= FILL_W'(count_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_status       = status_r;
  assign out_fill_count   = fill_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not remove one entry");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_func == FUNC_PUSH) && is_full |=> count_r == $past(count_r))
    else $error("dropped push changed the store");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("transfer accepted without a result");

  a_top_order: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> cell_q[0] >= cell_q[1])
    else $error("top two entries out of order");
`endif

endmodule
